[sv/nqpt_pkg.sv]
// Shared types, codes and field widths for the NVMe queue pair tracker.
// No dependencies; every other file of the block imports this package.
package nqpt_pkg;

    localparam int DEFAULT_QUEUE_DEPTH = 64;
    localparam int TABLE_SLOTS         = 64;
    localparam int PTR_W               = 6;
    localparam int SIZE_W              = 7;
    localparam int STATUS_W            = 15;
    localparam int CID_W               = 16;
    localparam int ACTION_W            = 2;
    localparam int CFG_INDEX_W         = 2;
    localparam int CFG_DATA_W          = 7;
    localparam int S_TDATA_W           = 40;
    localparam int M_TDATA_W           = 40;

    typedef enum logic [ACTION_W-1:0] {
        ACT_SUBMIT   = 2'd0,
        ACT_COMPLETE = 2'd1,
        ACT_POLL     = 2'd2,
        ACT_IGNORE   = 2'd3
    } action_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_QUEUE_SIZE  = 2'd0,
        REG_RECORD_CTX  = 2'd1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic capture;
        logic execute;
    } nqpt_cmd_t;

endpackage

[sv/nqpt_ctrl.sv]
// Controller state machine of the queue pair tracker.
// Depends on nqpt_pkg; drives the handshakes and the datapath commands.
module nqpt_ctrl
    import nqpt_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  logic      m_tready,
    output nqpt_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready    = 1'b0;
        m_tvalid    = 1'b0;
        cmd.capture = 1'b0;
        cmd.execute = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            ST_EXEC: begin
                cmd.execute = 1'b1;
            end
            ST_OUT: begin
                m_tvalid = 1'b1;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    a_capture_then_execute: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.capture |=> cmd.execute)
        else $error("Captured item was not executed in the next cycle.");

    a_execute_then_result: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.execute |=> m_tvalid)
        else $error("Executed item did not present a result.");

    a_one_side_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("Input ready while a result is pending.");

endmodule

[sv/nqpt_datapath.sv]
// Datapath of the queue pair tracker: pointers, phase, configuration and context table.
// Depends on nqpt_pkg; sequenced by the commands from nqpt_ctrl.
module nqpt_datapath
    import nqpt_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  nqpt_cmd_t              cmd,
    input  logic [S_TDATA_W-1:0]   s_tdata,
    input  logic [ACTION_W-1:0]    s_tuser,
    input  logic                   cfg_wr,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output logic [M_TDATA_W-1:0]   m_tdata
);

    localparam int CAP_RAW = (QUEUE_DEPTH < TABLE_SLOTS) ? QUEUE_DEPTH : TABLE_SLOTS;
    localparam int CAP     = (CAP_RAW < 2) ? 2 : CAP_RAW;
    localparam logic [SIZE_W-1:0] CAP_W = SIZE_W'(CAP);
    localparam logic [SIZE_W-1:0] MIN_W = SIZE_W'(2);
    localparam int OUT_USED = 3 * PTR_W + 3 + STATUS_W;

    logic [SIZE_W-1:0]      qsize_reg;
    logic                   rec_reg;
    logic [PTR_W-1:0]       tail_reg;
    logic [PTR_W-1:0]       tail_next;
    logic [PTR_W-1:0]       head_reg;
    logic [PTR_W-1:0]       head_next;
    logic                   phase_reg;
    logic                   phase_next;
    logic [TABLE_SLOTS-1:0] done_reg;
    logic [TABLE_SLOTS-1:0] done_next;
    logic [TABLE_SLOTS-1:0] svld_reg;
    logic [TABLE_SLOTS-1:0] svld_next;
    logic [STATUS_W-1:0]    status_mem [TABLE_SLOTS];
    logic [STATUS_W-1:0]    rd_status_reg;
    logic [ACTION_W-1:0]    act_reg;
    logic                   eph_reg;
    logic [STATUS_W-1:0]    est_reg;
    logic [CID_W-1:0]       cid_reg;
    logic [PTR_W-1:0]       qid_reg;
    logic [M_TDATA_W-1:0]   out_reg;

    logic [SIZE_W-1:0]      size_c;
    logic [SIZE_W-1:0]      tail_inc;
    logic [SIZE_W-1:0]      head_inc;
    logic [PTR_W-1:0]       tail_adv;
    logic [PTR_W-1:0]       head_adv;
    logic                   wr_en;
    logic [PTR_W-1:0]       wr_addr;
    logic [STATUS_W-1:0]    wr_data;
    logic [PTR_W-1:0]       assigned;
    logic                   consumed;
    logic                   done_bit;
    logic [STATUS_W-1:0]    rstat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            qsize_reg <= SIZE_W'(TABLE_SLOTS);
            rec_reg   <= 1'b1;
        end else if (cfg_wr) begin
            case (cfg_reg_t'(cfg_index))
                REG_QUEUE_SIZE: qsize_reg <= cfg_data[SIZE_W-1:0];
                REG_RECORD_CTX: rec_reg   <= cfg_data[0];
                default:        rec_reg   <= rec_reg;
            endcase
        end
    end

    always_comb begin
        if (qsize_reg < MIN_W) begin
            size_c = MIN_W;
        end else if (qsize_reg > CAP_W) begin
            size_c = CAP_W;
        end else begin
            size_c = qsize_reg;
        end
        tail_inc = {1'b0, tail_reg} + SIZE_W'(1);
        head_inc = {1'b0, head_reg} + SIZE_W'(1);
        tail_adv = (tail_inc >= size_c) ? '0 : tail_inc[PTR_W-1:0];
        head_adv = (head_inc >= size_c) ? '0 : head_inc[PTR_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            act_reg       <= s_tuser;
            eph_reg       <= s_tdata[0];
            est_reg       <= s_tdata[STATUS_W:1];
            cid_reg       <= s_tdata[CID_W+15:16];
            qid_reg       <= s_tdata[PTR_W+31:32];
            rd_status_reg <= status_mem[s_tdata[PTR_W+31:32]];
        end
    end

    always_comb begin
        tail_next  = tail_reg;
        head_next  = head_reg;
        phase_next = phase_reg;
        done_next  = done_reg;
        svld_next  = svld_reg;
        wr_en      = 1'b0;
        wr_addr    = tail_reg;
        wr_data    = '0;
        assigned   = '0;
        consumed   = 1'b0;
        done_bit   = 1'b0;
        rstat      = '0;
        case (action_t'(act_reg))
            ACT_SUBMIT: begin
                assigned = tail_reg;
                if (rec_reg) begin
                    wr_en               = 1'b1;
                    done_next[tail_reg] = 1'b0;
                end
                tail_next = tail_adv;
            end
            ACT_COMPLETE: begin
                if (eph_reg == phase_reg) begin
                    consumed = 1'b1;
                    rstat    = est_reg;
                    if (rec_reg && (cid_reg < {{(CID_W-SIZE_W){1'b0}}, size_c})) begin
                        wr_en                        = 1'b1;
                        wr_addr                      = cid_reg[PTR_W-1:0];
                        wr_data                      = est_reg;
                        done_next[cid_reg[PTR_W-1:0]] = 1'b1;
                    end
                    head_next = head_adv;
                    if (head_adv == '0) begin
                        phase_next = ~phase_reg;
                    end
                end
            end
            ACT_POLL: begin
                done_bit = done_reg[qid_reg];
                rstat    = svld_reg[qid_reg] ? rd_status_reg : '0;
            end
            default: begin
                assigned = '0;
            end
        endcase
        if (wr_en) begin
            svld_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tail_reg  <= '0;
            head_reg  <= '0;
            phase_reg <= 1'b1;
            done_reg  <= '0;
            svld_reg  <= '0;
        end else if (cmd.execute) begin
            tail_reg  <= tail_next;
            head_reg  <= head_next;
            phase_reg <= phase_next;
            done_reg  <= done_next;
            svld_reg  <= svld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.execute && wr_en) begin
            status_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.execute) begin
            out_reg <= {{(M_TDATA_W-OUT_USED){1'b0}}, (rstat != '0), rstat, done_bit,
                        consumed, head_next, tail_next, assigned};
        end
    end

    assign m_tdata = out_reg;

    a_size_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (size_c >= MIN_W) && (size_c <= CAP_W))
        else $error("Queue size in effect left its legal range.");

    a_phase_flips_at_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg != $past(phase_reg)) |-> (head_reg == '0))
        else $error("Expected phase changed without the head wrapping.");

    a_pointers_move_on_execute: assert property (@(posedge aclk) disable iff (!aresetn)
        ((head_reg != $past(head_reg)) || (tail_reg != $past(tail_reg))) |->
        $past(cmd.execute))
        else $error("Queue pointer moved outside an execute cycle.");

endmodule

[sv/nvme_queue_pair_tracker.sv]
// Host-side tracker for one NVMe-style queue pair with completion phase tags.
// Each item passes through capture, where it is registered and the context table is read,
// then execute, then output, where the result is held until m_tready takes it; the
// next item is accepted only after that. The order is set by the controller sequence around
// the registered read of the single-port status memory. The 64-entry status memory needs no
// clearing pass after reset: a written mark per entry makes unwritten entries read as zero.
// Depends on nqpt_pkg, nqpt_ctrl and nqpt_datapath.
module nvme_queue_pair_tracker
    import nqpt_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // Fields from bit 0: entry_phase, entry_status, entry_command_id, query_id, zero fill.
    input  logic [S_TDATA_W-1:0]   s_tdata,
    // Fields from bit 0: action.
    input  logic [ACTION_W-1:0]    s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // Fields from bit 0: assigned_id, submit_doorbell, complete_doorbell, consumed,
    // is_done, result_status, failed, zero fill.
    output logic [M_TDATA_W-1:0]   m_tdata,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    nqpt_cmd_t cmd;

    assign cfg_ready = 1'b1;

    nqpt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    nqpt_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_wr    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tdata   (m_tdata)
    );

endmodule

[verif/nqpt_queue_checker.sv]
// Checker for the NVMe queue pair tracker: watches the input, result and register channels,
// keeps its own copy of the ring pointers, phase and command contexts, and compares results.
// Depends on nqpt_pkg for field widths, action codes and register indexes.
`timescale 1ns / 100ps

module nqpt_queue_checker
    import nqpt_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,
    input  logic [ACTION_W-1:0]    s_tuser,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [M_TDATA_W-1:0]   m_tdata,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     fail_count,
    output int                     pending
);

    // Packed from the top bit down, so assigned_id lands in bit 0 as on m_tdata.
    typedef struct packed {
        logic                failed;
        logic [STATUS_W-1:0] result_status;
        logic                is_done;
        logic                consumed;
        logic [PTR_W-1:0]    complete_doorbell;
        logic [PTR_W-1:0]    submit_doorbell;
        logic [PTR_W-1:0]    assigned_id;
    } tracker_report_t;

    localparam int REPORT_W = $bits(tracker_report_t);

    logic [SIZE_W-1:0]   qsize_reg;
    logic                record_reg;
    logic [PTR_W-1:0]    sq_tail;
    logic [PTR_W-1:0]    cq_head;
    logic                cq_exp_phase;
    logic                done_flag [TABLE_SLOTS];
    logic [STATUS_W-1:0] ctx_status [TABLE_SLOTS];
    tracker_report_t     tracker_reports_q [$];

    function automatic int ring_size();
        int cap;
        int sz;
        cap = (QUEUE_DEPTH < TABLE_SLOTS) ? QUEUE_DEPTH : TABLE_SLOTS;
        if (cap < 2) cap = 2;
        sz = int'(qsize_reg);
        if (sz < 2) sz = 2;
        if (sz > cap) sz = cap;
        return sz;
    endfunction

    function automatic logic [PTR_W-1:0] ring_next(logic [PTR_W-1:0] ptr, int size);
        int nxt;
        nxt = int'(ptr) + 1;
        return (nxt >= size) ? '0 : nxt[PTR_W-1:0];
    endfunction

    function automatic tracker_report_t step_queue_pair(action_t act, logic phase,
                                                        logic [STATUS_W-1:0] status,
                                                        logic [CID_W-1:0] cid,
                                                        logic [PTR_W-1:0] qid);
        tracker_report_t r;
        int size;
        size = ring_size();
        r = '0;
        case (act)
            ACT_SUBMIT: begin
                r.assigned_id = sq_tail;
                if (record_reg) begin
                    done_flag[sq_tail]  = 1'b0;
                    ctx_status[sq_tail] = '0;
                end
                sq_tail = ring_next(sq_tail, size);
            end
            ACT_COMPLETE: begin
                if (phase == cq_exp_phase) begin
                    r.consumed      = 1'b1;
                    r.result_status = status;
                    if (record_reg && int'(cid) < size) begin
                        done_flag[cid[PTR_W-1:0]]  = 1'b1;
                        ctx_status[cid[PTR_W-1:0]] = status;
                    end
                    cq_head = ring_next(cq_head, size);
                    if (cq_head == '0) cq_exp_phase = ~cq_exp_phase;
                end
            end
            ACT_POLL: begin
                r.is_done       = done_flag[qid];
                r.result_status = ctx_status[qid];
            end
            default: ;
        endcase
        r.submit_doorbell   = sq_tail;
        r.complete_doorbell = cq_head;
        r.failed            = (r.result_status != '0);
        return r;
    endfunction

    task automatic compare_field(string name, int want, int got);
        if (want != got) begin
            $error("field %s expected %0d actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin : monitor
        tracker_report_t want;
        tracker_report_t got;
        if (!aresetn) begin
            fail_count   = 0;
            qsize_reg    = SIZE_W'(TABLE_SLOTS);
            record_reg   = 1'b1;
            sq_tail      = '0;
            cq_head      = '0;
            cq_exp_phase = 1'b1;
            for (int i = 0; i < TABLE_SLOTS; i++) begin
                done_flag[i]  = 1'b0;
                ctx_status[i] = '0;
            end
            tracker_reports_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_reg_t'(cfg_index))
                    REG_QUEUE_SIZE: qsize_reg = cfg_data;
                    REG_RECORD_CTX: record_reg = cfg_data[0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata[REPORT_W-1:0];
                if (tracker_reports_q.size() == 0) begin
                    $error("result item arrived with no item outstanding");
                    fail_count++;
                end else begin
                    want = tracker_reports_q.pop_front();
                    compare_field("assigned_id", want.assigned_id, got.assigned_id);
                    compare_field("submit_doorbell", want.submit_doorbell, got.submit_doorbell);
                    compare_field("complete_doorbell", want.complete_doorbell,
                                  got.complete_doorbell);
                    compare_field("consumed", want.consumed, got.consumed);
                    compare_field("is_done", want.is_done, got.is_done);
                    compare_field("result_status", want.result_status, got.result_status);
                    compare_field("failed", want.failed, got.failed);
                end
            end
            if (s_tvalid && s_tready) begin
                tracker_reports_q.push_back(step_queue_pair(action_t'(s_tuser), s_tdata[0],
                                                            s_tdata[15:1], s_tdata[31:16],
                                                            s_tdata[37:32]));
            end
        end
        pending = tracker_reports_q.size();
    end

endmodule

[verif/tb_top.sv]
// Testbench top for the NVMe queue pair tracker: clock, reset, register writes, directed and
// random items with random stalls on both sides, and the verdict. Needs nqpt_pkg, the block
// and nqpt_queue_checker, which does all prediction and comparison.
`timescale 1ns / 100ps

module tb_top;
    import nqpt_pkg::*;

    localparam int RESET_CYCLES = 8;
    localparam int STALL_LIMIT  = 2000;
    localparam int PHASE_ITEMS  = 200;
    localparam int NUM_PHASES   = 8;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic [ACTION_W-1:0]    s_tuser   = ACT_SUBMIT;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = REG_QUEUE_SIZE;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    int                     fail_count;
    int                     pending;

    // Host-side view used only to shape the stimulus.
    int               host_size  = TABLE_SLOTS;
    logic [PTR_W-1:0] host_tail  = '0;
    logic [PTR_W-1:0] host_head  = '0;
    logic             host_phase = 1'b1;
    logic [PTR_W-1:0] in_flight [$];
    bit               steady     = 1'b0;

    always #5 aclk = ~aclk;

    nvme_queue_pair_tracker u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    nqpt_queue_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    function automatic logic [PTR_W-1:0] host_next(logic [PTR_W-1:0] ptr);
        return (int'(ptr) + 1 >= host_size) ? '0 : ptr + 1'b1;
    endfunction

    task automatic send_item(action_t act, logic phase, logic [STATUS_W-1:0] status,
                             logic [CID_W-1:0] cid, logic [PTR_W-1:0] qid);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tuser  <= act;
        s_tdata  <= {2'b00, qid, cid, status, phase};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        @(negedge aclk);
        if (act == ACT_SUBMIT) begin
            if (in_flight.size() < host_size) in_flight.push_back(host_tail);
            host_tail = host_next(host_tail);
        end else if (act == ACT_COMPLETE && phase == host_phase) begin
            host_head = host_next(host_head);
            if (host_head == '0) host_phase = ~host_phase;
        end
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (6) @(negedge aclk);
    endtask

    task automatic set_register(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
        if (idx == REG_QUEUE_SIZE) begin
            host_size = (val < 2) ? 2 : ((val > TABLE_SLOTS) ? TABLE_SLOTS : int'(val));
            in_flight.delete();
        end
    endtask

    function automatic logic [CID_W-1:0] pick_in_flight();
        int k;
        logic [CID_W-1:0] cid;
        if (in_flight.size() == 0) return CID_W'($urandom_range(0, host_size - 1));
        k = $urandom_range(0, in_flight.size() - 1);
        cid = CID_W'(in_flight[k]);
        in_flight.delete(k);
        return cid;
    endfunction

    initial begin : result_sink
        int gap;
        forever begin
            gap = steady ? 0 : $urandom_range(0, 15);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
            @(negedge aclk);
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("FAIL nvme_queue_pair_tracker");
        $finish;
    end

    initial begin : stimulus
        int sizes [NUM_PHASES];
        int records [NUM_PHASES];
        int sent;
        int roll;
        logic [CID_W-1:0] cid;
        logic [STATUS_W-1:0] status;
        sizes   = '{64, 2, 127, 1, 5, 0, 13, 64};
        records = '{1, 1, 0, 1, 1, 0, 1, 1};

        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset settings: full-size rings with contexts kept.
        send_item(ACT_SUBMIT, 1'b0, '0, '0, '0);
        send_item(ACT_COMPLETE, host_phase, 15'h7FFF, 16'h0000, '0);
        send_item(ACT_POLL, 1'b0, '0, '0, 6'd0);
        send_item(ACT_COMPLETE, ~host_phase, 15'h7FFF, 16'hFFFF, 6'h3F);
        send_item(ACT_COMPLETE, host_phase, 15'h0000, 16'hFFFF, '0);
        send_item(ACT_POLL, 1'b1, 15'h7FFF, 16'hFFFF, 6'd63);
        send_item(ACT_IGNORE, 1'b1, 15'h7FFF, 16'hFFFF, 6'h3F);
        send_item(ACT_SUBMIT, 1'b1, 15'h7FFF, 16'hFFFF, 6'h3F);
        send_item(ACT_COMPLETE, host_phase, 15'h0001, 16'h0001, '0);
        send_item(ACT_POLL, 1'b0, '0, '0, 6'd1);

        // Smallest ring: both pointers already past the end, then phase flips on wrap.
        settle();
        set_register(REG_QUEUE_SIZE, 7'd0);
        send_item(ACT_SUBMIT, 1'b0, '0, '0, '0);
        send_item(ACT_SUBMIT, 1'b0, '0, '0, '0);
        send_item(ACT_COMPLETE, host_phase, 15'h0005, 16'h0000, '0);
        send_item(ACT_COMPLETE, host_phase, 15'h0000, 16'h0001, '0);
        send_item(ACT_COMPLETE, host_phase, 15'h4000, 16'h0002, '0);
        send_item(ACT_POLL, 1'b0, '0, '0, 6'd0);
        send_item(ACT_POLL, 1'b0, '0, '0, 6'd2);

        // Polled mode with an oversized size setting.
        settle();
        set_register(REG_RECORD_CTX, 7'd0);
        set_register(REG_QUEUE_SIZE, 7'd127);
        send_item(ACT_SUBMIT, 1'b0, '0, '0, '0);
        send_item(ACT_COMPLETE, host_phase, 15'h2AAA, CID_W'(in_flight[0]), '0);
        send_item(ACT_POLL, 1'b0, '0, '0, in_flight[0]);
        send_item(ACT_COMPLETE, host_phase, 15'h5555, 16'h0000, '0);
        send_item(ACT_POLL, 1'b0, '0, '0, 6'd0);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            settle();
            set_register(REG_QUEUE_SIZE, CFG_DATA_W'(sizes[ph]));
            set_register(REG_RECORD_CTX, CFG_DATA_W'(records[ph]));
            steady = (ph % 3 == 2);
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                roll = $urandom_range(0, 99);
                status = ($urandom_range(0, 3) == 0) ? STATUS_W'($urandom) : '0;
                if (roll < 35 && in_flight.size() < host_size) begin
                    send_item(ACT_SUBMIT, 1'($urandom), STATUS_W'($urandom), CID_W'($urandom),
                              PTR_W'($urandom));
                end else if (roll < 75) begin
                    cid = pick_in_flight();
                    send_item(ACT_COMPLETE, host_phase, status, cid, PTR_W'($urandom));
                end else if (roll < 83) begin
                    send_item(ACT_COMPLETE, ~host_phase, STATUS_W'($urandom), CID_W'($urandom),
                              PTR_W'($urandom));
                end else if (roll < 88) begin
                    cid = CID_W'($urandom_range(host_size, 65535));
                    send_item(ACT_COMPLETE, host_phase, STATUS_W'($urandom), cid,
                              PTR_W'($urandom));
                end else if (roll < 97) begin
                    send_item(ACT_POLL, 1'($urandom), STATUS_W'($urandom), CID_W'($urandom),
                              PTR_W'($urandom_range(0, 63)));
                end else begin
                    send_item(ACT_IGNORE, 1'($urandom), STATUS_W'($urandom), CID_W'($urandom),
                              PTR_W'($urandom));
                    sent--;
                end
                sent++;
            end
        end

        settle();
        if (fail_count == 0)
            $display("PASS nvme_queue_pair_tracker");
        else
            $display("FAIL nvme_queue_pair_tracker");
        $finish;
    end

endmodule
